// ===== sv/cbe_pkg.sv =====
// shared types, constants and Q2.30 arithmetic helpers for the easing block
`default_nettype none

package cbe_pkg;

    typedef logic signed [31:0] q_t;
    typedef logic signed [35:0] w_t;
    typedef logic [31:0]        mag_t;

    localparam q_t   Q_ONE     = 32'sh4000_0000;
    localparam q_t   Q_MAX     = 32'sh7fff_ffff;
    localparam q_t   Q_MIN     = 32'sh8000_0000;
    localparam mag_t SLOPE_MIN = 32'h0000_0400;

    typedef enum logic [1:0] {
        REG_CTRL_X1 = 2'd0,
        REG_CTRL_Y1 = 2'd1,
        REG_CTRL_X2 = 2'd2,
        REG_CTRL_Y2 = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               spec;
        logic signed [15:0] spec_val;
        logic               done;
        q_t                 x;
        q_t                 t;
    } item_t;

    function automatic w_t w_ext(input q_t v);
        return w_t'(v);
    endfunction

    function automatic q_t q_sat(input w_t v);
        if (v > w_ext(Q_MAX))
            return Q_MAX;
        if (v < w_ext(Q_MIN))
            return Q_MIN;
        return q_t'(v);
    endfunction

    function automatic mag_t q_mag(input q_t v);
        return v[31] ? mag_t'(-v) : mag_t'(v);
    endfunction

    function automatic q_t q_add(input q_t a, input q_t b);
        return q_sat(w_ext(a) + w_ext(b));
    endfunction

    function automatic q_t q_sub(input q_t a, input q_t b);
        return q_sat(w_ext(a) - w_ext(b));
    endfunction

    function automatic q_t q_mul3(input q_t a);
        return q_sat((w_ext(a) <<< 1) + w_ext(a));
    endfunction

    function automatic q_t q_mul6(input q_t a);
        return q_sat((w_ext(a) <<< 2) + (w_ext(a) <<< 1));
    endfunction

    // sign-magnitude product, truncated toward zero
    function automatic q_t q_mul(input q_t a, input q_t b);
        logic [63:0] p;
        w_t          r;
        p = 64'(q_mag(a)) * 64'(q_mag(b));
        r = w_t'({3'b000, p[62:30]});
        if (a[31] ^ b[31])
            r = -r;
        return q_sat(r);
    endfunction

endpackage

`default_nettype wire

// ===== sv/cbe_poly.sv =====
// five-stage evaluator of the bezier polynomial and its slope at t
`default_nettype none

module cbe_poly
    import cbe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_vld,
    input  wire item_t in_item,
    input  wire q_t    p1,
    input  wire q_t    p2,
    output logic       out_vld,
    output item_t      out_item,
    output q_t         out_cx,
    output q_t         out_slope
);

    logic  s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    item_t s1_it_reg, s2_it_reg, s3_it_reg, s4_it_reg, s5_it_reg;
    q_t    s1_t_reg, s1_tt_reg, s1_mt_reg;
    q_t    s2_t_reg, s2_ttt_reg, s2_mt2_reg, s2_mtt_reg, s2_mttt_reg, s2_sc_reg;
    q_t    s3_ttt_reg, s3_ca_reg, s3_cb_reg, s3_sa_reg, s3_sb_reg, s3_sc_reg;
    q_t    s4_ttt_reg, s4_ca_reg, s4_cb_reg, s4_slope_reg;
    q_t    s5_cx_reg, s5_slope_reg;
    q_t    omp2;
    q_t    d21;

    assign omp2 = q_sub(Q_ONE, p2);
    assign d21  = q_sub(p2, p1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_it_reg    <= in_item;
            s1_t_reg     <= in_item.t;
            s1_tt_reg    <= q_mul(in_item.t, in_item.t);
            s1_mt_reg    <= q_sub(Q_ONE, in_item.t);

            s2_it_reg    <= s1_it_reg;
            s2_t_reg     <= s1_t_reg;
            s2_ttt_reg   <= q_mul(s1_tt_reg, s1_t_reg);
            s2_mt2_reg   <= q_mul(s1_mt_reg, s1_mt_reg);
            s2_mtt_reg   <= q_mul(s1_mt_reg, s1_t_reg);
            s2_mttt_reg  <= q_mul(s1_mt_reg, s1_tt_reg);
            s2_sc_reg    <= q_mul(s1_tt_reg, omp2);

            s3_it_reg    <= s2_it_reg;
            s3_ttt_reg   <= s2_ttt_reg;
            s3_ca_reg    <= q_mul(s2_mt2_reg, s2_t_reg);
            s3_cb_reg    <= q_mul(s2_mttt_reg, p2);
            s3_sa_reg    <= q_mul(s2_mt2_reg, p1);
            s3_sb_reg    <= q_mul(s2_mtt_reg, d21);
            s3_sc_reg    <= s2_sc_reg;

            s4_it_reg    <= s3_it_reg;
            s4_ttt_reg   <= s3_ttt_reg;
            s4_ca_reg    <= q_mul(s3_ca_reg, p1);
            s4_cb_reg    <= q_mul3(s3_cb_reg);
            s4_slope_reg <= q_add(q_add(q_mul3(s3_sa_reg), q_mul6(s3_sb_reg)),
                                  q_mul3(s3_sc_reg));

            s5_it_reg    <= s4_it_reg;
            s5_cx_reg    <= q_add(q_add(q_mul3(s4_ca_reg), s4_cb_reg), s4_ttt_reg);
            s5_slope_reg <= s4_slope_reg;
        end
    end

    assign out_vld   = s5_vld_reg;
    assign out_item  = s5_it_reg;
    assign out_cx    = s5_cx_reg;
    assign out_slope = s5_slope_reg;

endmodule

`default_nettype wire

// ===== sv/cbe_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module cbe_div
    import cbe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_vld,
    input  wire item_t      in_item,
    input  wire mag_t       in_md,
    input  wire mag_t       in_rem,
    input  wire logic [1:0] in_lo,
    input  wire logic       in_neg,
    input  wire logic       in_ovf,
    output logic            out_vld,
    output item_t           out_item,
    output mag_t            out_quo,
    output logic            out_neg,
    output logic            out_ovf
);

    localparam int NBITS = 32;

    logic       vld_reg [1:NBITS];
    item_t      it_reg  [1:NBITS];
    mag_t       rem_reg [1:NBITS];
    mag_t       quo_reg [1:NBITS];
    logic       neg_reg [1:NBITS];
    logic       ovf_reg [1:NBITS];
    mag_t       md_reg  [1:NBITS-1];
    logic [1:0] lo_reg  [1:NBITS-1];

    for (genvar k = 0; k < NBITS; k++)
    begin : g_bit
        logic        s_vld;
        item_t       s_it;
        mag_t        s_md;
        mag_t        s_rem;
        mag_t        s_quo;
        logic [1:0]  s_lo;
        logic        s_neg;
        logic        s_ovf;
        logic        nbit;
        logic [32:0] rs;
        logic [33:0] diff;
        mag_t        rem_next;
        mag_t        quo_next;

        if (k == 0)
        begin : g_src
            assign s_vld = in_vld;
            assign s_it  = in_item;
            assign s_md  = in_md;
            assign s_rem = in_rem;
            assign s_quo = '0;
            assign s_lo  = in_lo;
            assign s_neg = in_neg;
            assign s_ovf = in_ovf;
        end
        else
        begin : g_src
            assign s_vld = vld_reg[k];
            assign s_it  = it_reg[k];
            assign s_md  = md_reg[k];
            assign s_rem = rem_reg[k];
            assign s_quo = quo_reg[k];
            assign s_lo  = lo_reg[k];
            assign s_neg = neg_reg[k];
            assign s_ovf = ovf_reg[k];
        end

        // only the two low dividend bits of the magnitude are nonzero
        assign nbit = (k == 0) ? s_lo[1] : ((k == 1) ? s_lo[0] : 1'b0);

        always_comb
        begin
            rs       = {s_rem, nbit};
            diff     = {1'b0, rs} - {2'b00, s_md};
            quo_next = s_quo;
            quo_next[NBITS-1-k] = ~diff[33];
            rem_next = diff[33] ? rs[31:0] : diff[31:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= s_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                it_reg[k+1]  <= s_it;
                rem_reg[k+1] <= rem_next;
                quo_reg[k+1] <= quo_next;
                neg_reg[k+1] <= s_neg;
                ovf_reg[k+1] <= s_ovf;
            end
        end

        if (k < NBITS - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    md_reg[k+1] <= s_md;
                    lo_reg[k+1] <= s_lo;
                end
            end
        end
    end

    assign out_vld  = vld_reg[NBITS];
    assign out_item = it_reg[NBITS];
    assign out_quo  = quo_reg[NBITS];
    assign out_neg  = neg_reg[NBITS];
    assign out_ovf  = ovf_reg[NBITS];

endmodule

`default_nettype wire

// ===== sv/cbe_newton.sv =====
// one newton step: polynomial, error and slope, divider, update of t
`default_nettype none

module cbe_newton
    import cbe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_vld,
    input  wire item_t in_item,
    input  wire q_t    x1,
    input  wire q_t    x2,
    output logic       out_vld,
    output item_t      out_item
);

    logic       p_vld;
    item_t      p_it;
    q_t         p_cx;
    q_t         p_slope;

    logic       e1_vld_reg;
    item_t      e1_it_reg;
    q_t         e1_err_reg;
    q_t         e1_slope_reg;
    logic       e1_flat_reg;

    logic       e2_vld_reg;
    item_t      e2_it_reg;
    mag_t       e2_md_reg;
    mag_t       e2_rem_reg;
    logic [1:0] e2_lo_reg;
    logic       e2_neg_reg;
    logic       e2_ovf_reg;
    item_t      e2_it_next;
    mag_t       mn;
    mag_t       md;

    logic       d_vld;
    item_t      d_it;
    mag_t       d_quo;
    logic       d_neg;
    logic       d_ovf;

    logic       u_vld_reg;
    item_t      u_it_reg;
    item_t      u_it_next;
    mag_t       qc;
    w_t         step;

    cbe_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (in_vld),
        .in_item   (in_item),
        .p1        (x1),
        .p2        (x2),
        .out_vld   (p_vld),
        .out_item  (p_it),
        .out_cx    (p_cx),
        .out_slope (p_slope)
    );

    always_comb
    begin
        mn = q_mag(e1_err_reg);
        md = q_mag(e1_slope_reg);
        e2_it_next = e1_it_reg;
        e2_it_next.done = e1_it_reg.done | e1_flat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            u_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            e1_vld_reg <= p_vld;
            e2_vld_reg <= e1_vld_reg;
            u_vld_reg  <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_it_reg    <= p_it;
            e1_err_reg   <= q_sub(p_cx, p_it.x);
            e1_slope_reg <= p_slope;
            e1_flat_reg  <= q_mag(p_slope) < SLOPE_MIN;

            e2_it_reg    <= e2_it_next;
            e2_md_reg    <= md;
            e2_rem_reg   <= {2'b00, mn[31:2]};
            e2_lo_reg    <= mn[1:0];
            e2_neg_reg   <= e1_err_reg[31] ^ e1_slope_reg[31];
            // quotient reaches 2^32 or more
            e2_ovf_reg   <= {2'b00, mn} >= {md, 2'b00};

            u_it_reg     <= u_it_next;
        end
    end

    cbe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (e2_vld_reg),
        .in_item  (e2_it_reg),
        .in_md    (e2_md_reg),
        .in_rem   (e2_rem_reg),
        .in_lo    (e2_lo_reg),
        .in_neg   (e2_neg_reg),
        .in_ovf   (e2_ovf_reg),
        .out_vld  (d_vld),
        .out_item (d_it),
        .out_quo  (d_quo),
        .out_neg  (d_neg),
        .out_ovf  (d_ovf)
    );

    // quotient magnitude limited to 2^31, positive side then to Q_MAX
    always_comb
    begin
        if (d_ovf || (d_quo[31] && (|d_quo[30:0])))
            qc = 32'h8000_0000;
        else
            qc = d_quo;
        if (d_neg)
            step = -w_t'(qc);
        else if (qc[31])
            step = w_ext(Q_MAX);
        else
            step = w_t'(qc);
        u_it_next = d_it;
        if (!d_it.done)
            u_it_next.t = q_sat(w_ext(d_it.t) - step);
    end

    assign out_vld  = u_vld_reg;
    assign out_item = u_it_reg;

endmodule

`default_nettype wire

// ===== sv/cubic_bezier_easing.sv =====
// top level: config registers, input stage, newton chain, y evaluation, output
//
//  channel    dir  handshake                       payload
//  progress   in   progress_valid/progress_ready   progress  (signed q2.14)
//  eased      out  eased_valid/eased_ready         eased     (signed q2.14)
//  config     in   cfg_we                          cfg_index, cfg_data
//
//  one request per cycle while the output is not stalled
//  each newton step is 40 stages, of which the 32-stage quotient pipeline is the bulk
//  reset clears all valid bits and loads the control points with their defaults
//  a stalled output freezes the whole pipeline, progress_ready drops in the same cycle
`default_nettype none

module cubic_bezier_easing
    import cbe_pkg::*;
#(
    parameter int NEWTON_STEPS = 8,
    parameter int FRAC_BITS    = 14
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               progress_valid,
    output logic                    progress_ready,
    input  wire logic signed [15:0] progress,
    output logic                    eased_valid,
    input  wire logic               eased_ready,
    output logic signed [15:0]      eased,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int                 ISHIFT   = 30 - FRAC_BITS;
    localparam logic [31:0]        PONE_U   = 32'(1) << FRAC_BITS;
    localparam logic signed [15:0] SPEC_ONE = (FRAC_BITS >= 15) ? 16'sh7fff : 16'(PONE_U);

    function automatic q_t to_q(input logic signed [15:0] v);
        return q_sat(w_t'(v) <<< ISHIFT);
    endfunction

    function automatic q_t x_to_q(input logic [14:0] r);
        logic [31:0] v;
        v = {17'b0, r};
        if (v > PONE_U)
            v = PONE_U;
        return to_q(signed'(v[15:0]));
    endfunction

    logic [14:0]        x1_reg;
    logic signed [15:0] y1_reg;
    logic [14:0]        x2_reg;
    logic signed [15:0] y2_reg;
    q_t                 x1q, x2q, y1q, y2q;

    logic               en;
    logic               in_vld_reg;
    item_t              in_it_reg;
    item_t              in_it_next;

    logic               nv  [0:NEWTON_STEPS];
    item_t              nit [0:NEWTON_STEPS];

    logic               ck_vld_reg;
    item_t              ck_it_reg;
    item_t              ck_it_next;

    logic               yv;
    item_t              yit;
    q_t                 ycx;

    logic               out_vld_reg;
    logic signed [15:0] eased_reg;
    logic signed [15:0] eased_next;
    mag_t               ym;
    w_t                 yres;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= 15'd2621;
            y1_reg <= 16'sd16384;
            x2_reg <= 15'd4915;
            y2_reg <= 16'sd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CTRL_X1: x1_reg <= cfg_data[14:0];
                REG_CTRL_Y1: y1_reg <= signed'(cfg_data);
                REG_CTRL_X2: x2_reg <= cfg_data[14:0];
                REG_CTRL_Y2: y2_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    assign x1q = x_to_q(x1_reg);
    assign x2q = x_to_q(x2_reg);
    assign y1q = to_q(y1_reg);
    assign y2q = to_q(y2_reg);

    assign en             = !out_vld_reg || eased_ready;
    assign progress_ready = en;

    // clamp progress outside the open unit interval
    always_comb
    begin
        in_it_next.done     = 1'b0;
        in_it_next.x        = to_q(progress);
        in_it_next.t        = to_q(progress);
        in_it_next.spec     = 1'b0;
        in_it_next.spec_val = '0;
        if (progress <= 16'sd0)
            in_it_next.spec = 1'b1;
        else if (w_t'(progress) >= w_t'(PONE_U))
        begin
            in_it_next.spec     = 1'b1;
            in_it_next.spec_val = SPEC_ONE;
        end
    end

    always_comb
    begin
        ck_it_next = nit[NEWTON_STEPS];
        if (nit[NEWTON_STEPS].t < 0)
            ck_it_next.t = '0;
        else if (nit[NEWTON_STEPS].t > Q_ONE)
            ck_it_next.t = Q_ONE;
    end

    always_comb
    begin
        ym   = q_mag(ycx) >> ISHIFT;
        yres = ycx[31] ? -w_t'(ym) : w_t'(ym);
        if (yit.spec)
            eased_next = yit.spec_val;
        else if (yres > 36'sd32767)
            eased_next = 16'sh7fff;
        else if (yres < -36'sd32768)
            eased_next = 16'sh8000;
        else
            eased_next = yres[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            ck_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            in_vld_reg  <= progress_valid;
            ck_vld_reg  <= nv[NEWTON_STEPS];
            out_vld_reg <= yv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_it_reg <= in_it_next;
            ck_it_reg <= ck_it_next;
            eased_reg <= eased_next;
        end
    end

    assign nv[0]  = in_vld_reg;
    assign nit[0] = in_it_reg;

    for (genvar k = 0; k < NEWTON_STEPS; k++)
    begin : g_step
        cbe_newton u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (nv[k]),
            .in_item  (nit[k]),
            .x1       (x1q),
            .x2       (x2q),
            .out_vld  (nv[k+1]),
            .out_item (nit[k+1])
        );
    end

    cbe_poly u_ypoly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (ck_vld_reg),
        .in_item   (ck_it_reg),
        .p1        (y1q),
        .p2        (y2q),
        .out_vld   (yv),
        .out_item  (yit),
        .out_cx    (ycx),
        .out_slope ()
    );

    assign eased_valid = out_vld_reg;
    assign eased       = eased_reg;

`ifndef SYNTH
    a_t_clamped : assert property (@(posedge clk) disable iff (!rst_n)
        ck_vld_reg |-> (ck_it_reg.t >= 0 && ck_it_reg.t <= Q_ONE))
        else $error("clamped t outside unit interval");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !progress_ready |=> ($stable(in_vld_reg) && $stable(ck_vld_reg)))
        else $error("pipeline moved during stall");

    a_ready_frees : assert property (@(posedge clk) disable iff (!rst_n)
        (eased_valid && eased_ready) |-> progress_ready)
        else $error("pipeline held after result taken");
`endif

endmodule

`default_nettype wire
